// ===== hw/rtl/owpsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owpsc_pkg
// Shared types, codes and the CRC-16 helper for the 1-Wire switch
// function-command unit.
// ----------------------------------------------------------------------------
package owpsc_pkg;

   localparam int READ_BURST = 32;
   localparam int COUNT_W    = 6;

   localparam int ACTION_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_RESET = 2'd0;
   localparam action_type ACT_WRITE = 2'd1;
   localparam action_type ACT_READ  = 2'd2;

   localparam logic [7:0] CMD_REG_READ   = 8'hF0;
   localparam logic [7:0] CMD_CHAN_READ  = 8'hF5;
   localparam logic [7:0] CMD_CHAN_WRITE = 8'h5A;
   localparam logic [7:0] CMD_STAT_WRITE = 8'hCC;
   localparam logic [7:0] CMD_ACT_RESET  = 8'hC3;

   localparam logic [7:0] ADDR_REG_FIRST  = 8'h88;
   localparam logic [7:0] ADDR_REG_LAST   = 8'h8F;
   localparam logic [7:0] ADDR_WRITE_LOW  = 8'h8B;
   localparam logic [7:0] ADDR_WRITE_MID  = 8'h8C;
   localparam logic [7:0] ADDR_WRITE_HIGH = 8'h8D;

   localparam logic [2:0] REG_PINS     = 3'd0;
   localparam logic [2:0] REG_OUTPUT   = 3'd1;
   localparam logic [2:0] REG_ACTIVITY = 3'd2;
   localparam logic [2:0] REG_MASK     = 3'd3;
   localparam logic [2:0] REG_POLARITY = 3'd4;
   localparam logic [2:0] REG_STATUS   = 3'd5;

   localparam logic [7:0] BYTE_ACK  = 8'hAA;
   localparam logic [7:0] BYTE_IDLE = 8'hFF;

   localparam logic [7:0] OUTPUT_RESET = 8'hFF;
   localparam logic [7:0] STATUS_RESET = 8'h88;

   localparam logic [15:0] CRC_POLY = 16'hA001;

   // One byte through the reflected 1-Wire CRC-16.
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/one_wire_pio_switch_commands_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// An accepted transaction passes through the input registers and then the
// result register that drives rsp; a stalled rsp holds both. Throughput: one
// transaction per cycle while rsp is not stalled, set by the combinational
// command decode and byte-wide CRC update between the input and result
// registers. Reset is synchronous and active high; it returns the command
// phase to idle and loads the register file reset values.
// ----------------------------------------------------------------------------
// one_wire_pio_switch_commands_unit
// Function-command layer of an 8-channel 1-Wire addressable switch: register
// read, channel read and write, status write and activity latch reset.
// ----------------------------------------------------------------------------
module one_wire_pio_switch_commands_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from low: bus_byte[7:0], pin_levels[15:8], activity_events[23:16].
   input  logic [owpsc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Bits from low: action[1:0].
   input  logic [owpsc_pkg::ACTION_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from low: read_byte[7:0], pin_drive[15:8].
   output logic [owpsc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import owpsc_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_PR_LO   = 4'd1,
      PH_PR_HI   = 4'd2,
      PH_PR_DATA = 4'd3,
      PH_CRC_LO  = 4'd4,
      PH_CRC_HI  = 4'd5,
      PH_CR_DATA = 4'd6,
      PH_CW_DATA = 4'd7,
      PH_CW_INV  = 4'd8,
      PH_CW_ACK  = 4'd9,
      PH_CW_ECHO = 4'd10,
      PH_WS_LO   = 4'd11,
      PH_WS_HI   = 4'd12,
      PH_WS_DATA = 4'd13,
      PH_AL_ACK  = 4'd14,
      PH_DONE    = 4'd15
   } phase_type;

   localparam logic [15:0]        CRC_REG_READ  = crc_add(16'h0000, CMD_REG_READ);
   localparam logic [15:0]        CRC_CHAN_READ = crc_add(16'h0000, CMD_CHAN_READ);
   localparam logic [COUNT_W-1:0] BURST_LEN     = COUNT_W'(READ_BURST);

   logic                  in_valid_ff;
   action_type            in_action_ff;
   logic [7:0]            in_byte_ff;
   logic [7:0]            in_pins_ff;
   logic [7:0]            in_events_ff;

   phase_type             phase_ff, phase_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [7:0]            target_ff, target_in;
   logic [7:0]            pending_ff, pending_in;
   logic [15:0]           crc_ff, crc_in;
   logic [7:0]            output_ff, output_in;
   logic [7:0]            activity_ff, activity_in;
   logic [7:0]            mask_ff, mask_in;
   logic [7:0]            polarity_ff, polarity_in;
   logic [7:0]            status_ff, status_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                  advance;
   logic [7:0]            read_value;
   logic [7:0]            reg_value;
   logic [7:0]            next_target;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (target_ff[2:0])
         REG_PINS:     reg_value = in_pins_ff;
         REG_OUTPUT:   reg_value = output_ff;
         REG_ACTIVITY: reg_value = activity_ff | in_events_ff;
         REG_MASK:     reg_value = mask_ff;
         REG_POLARITY: reg_value = polarity_ff;
         REG_STATUS:   reg_value = status_ff;
         default:      reg_value = BYTE_IDLE;
      endcase
   end

   assign next_target = target_ff + 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      target_in   = target_ff;
      pending_in  = pending_ff;
      crc_in      = crc_ff;
      output_in   = output_ff;
      activity_in = activity_ff | in_events_ff;
      mask_in     = mask_ff;
      polarity_in = polarity_ff;
      status_in   = status_ff;
      read_value  = BYTE_IDLE;
      case (in_action_ff)
         ACT_RESET: begin
            phase_in = PH_IDLE;
            count_in = '0;
         end
         ACT_WRITE: begin
            case (phase_ff)
               PH_IDLE: begin
                  case (in_byte_ff)
                     CMD_REG_READ:   phase_in = PH_PR_LO;
                     CMD_CHAN_READ: begin
                        crc_in   = CRC_CHAN_READ;
                        count_in = '0;
                        phase_in = PH_CR_DATA;
                     end
                     CMD_CHAN_WRITE: phase_in = PH_CW_DATA;
                     CMD_STAT_WRITE: phase_in = PH_WS_LO;
                     CMD_ACT_RESET: begin
                        activity_in = '0;
                        phase_in    = PH_AL_ACK;
                     end
                     default:        phase_in = PH_DONE;
                  endcase
               end
               PH_PR_LO: begin
                  target_in = in_byte_ff;
                  crc_in    = crc_add(CRC_REG_READ, in_byte_ff);
                  phase_in  = PH_PR_HI;
               end
               PH_PR_HI: begin
                  crc_in   = crc_add(crc_ff, in_byte_ff);
                  phase_in = PH_PR_DATA;
               end
               PH_CW_DATA: begin
                  pending_in = in_byte_ff;
                  phase_in   = PH_CW_INV;
               end
               PH_CW_INV: begin
                  if (in_byte_ff == ~pending_ff) begin
                     output_in = pending_ff;
                     phase_in  = PH_CW_ACK;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_WS_LO: begin
                  target_in = in_byte_ff;
                  phase_in  = PH_WS_HI;
               end
               PH_WS_HI: begin
                  if (target_ff >= ADDR_WRITE_LOW && target_ff <= ADDR_WRITE_HIGH) begin
                     phase_in = PH_WS_DATA;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_WS_DATA: begin
                  if (target_ff == ADDR_WRITE_LOW) begin
                     mask_in = in_byte_ff;
                  end else if (target_ff == ADDR_WRITE_MID) begin
                     polarity_in = in_byte_ff;
                  end else if (target_ff == ADDR_WRITE_HIGH) begin
                     status_in = (status_ff & 8'hF0) | (in_byte_ff & 8'h07)
                               | (status_ff & in_byte_ff & 8'h08);
                  end
                  target_in = next_target;
                  if (next_target > ADDR_WRITE_HIGH || next_target < ADDR_WRITE_LOW) begin
                     phase_in = PH_DONE;
                  end
               end
               default: ;
            endcase
         end
         ACT_READ: begin
            case (phase_ff)
               PH_PR_DATA: begin
                  if (target_ff >= ADDR_REG_FIRST && target_ff <= ADDR_REG_LAST) begin
                     read_value = reg_value;
                     crc_in     = crc_add(crc_ff, reg_value);
                     target_in  = next_target;
                  end else begin
                     read_value = ~crc_ff[7:0];
                     phase_in   = PH_CRC_HI;
                  end
               end
               PH_CR_DATA: begin
                  read_value = in_pins_ff;
                  crc_in     = crc_add(crc_ff, in_pins_ff);
                  count_in   = count_ff + COUNT_W'(1);
                  if (count_in >= BURST_LEN) begin
                     phase_in = PH_CRC_LO;
                  end
               end
               PH_CRC_LO: begin
                  read_value = ~crc_ff[7:0];
                  phase_in   = PH_CRC_HI;
               end
               PH_CRC_HI: begin
                  read_value = ~crc_ff[15:8];
                  phase_in   = PH_DONE;
               end
               PH_CW_ACK: begin
                  read_value = BYTE_ACK;
                  phase_in   = PH_CW_ECHO;
               end
               PH_CW_ECHO: begin
                  read_value = pending_ff;
                  phase_in   = PH_CW_DATA;
               end
               PH_AL_ACK: begin
                  read_value = BYTE_ACK;
                  phase_in   = PH_DONE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         target_ff    <= '0;
         pending_ff   <= '0;
         crc_ff       <= '0;
         output_ff    <= OUTPUT_RESET;
         activity_ff  <= '0;
         mask_ff      <= '0;
         polarity_ff  <= '0;
         status_ff    <= STATUS_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            phase_ff    <= phase_in;
            count_ff    <= count_in;
            target_ff   <= target_in;
            pending_ff  <= pending_in;
            crc_ff      <= crc_in;
            output_ff   <= output_in;
            activity_ff <= activity_in;
            mask_ff     <= mask_in;
            polarity_ff <= polarity_in;
            status_ff   <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata[7:0];
         in_pins_ff   <= req_tdata[15:8];
         in_events_ff <= req_tdata[23:16];
      end
      if (advance) begin
         rsp_data_ff <= {~output_in, read_value};
      end
   end

endmodule

// ===== hw/rtl/owpsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owpsc_checker
// Port-level checks for the 1-Wire switch function-command unit.
// ----------------------------------------------------------------------------
module owpsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [owpsc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic [owpsc_pkg::ACTION_W-1:0]      req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [owpsc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import owpsc_pkg::*;

   logic [REQ_DATA_W+ACTION_W-1:0] req_seen;

   assign req_seen = {req_tdata, req_tuser};

   // A stalled result transaction holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // With the result side ready, the unit never back-pressures its input.
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled although rsp is ready");

   // An accepted transaction reaches rsp when rsp does not stall it.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && $countones(req_seen) >= 0) ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("result transaction missing after acceptance");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result pending straight after reset");

endmodule

bind one_wire_pio_switch_commands_unit owpsc_checker u_owpsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
